### rtl/lgr_pkg.sv
// Shared types and constants for the Life generation row stream block.
package lgr_pkg;

    // Board row width in bits, fixed by the row fields.
    localparam int unsigned ROW_BITS = 64;

    // Width of the row width register.
    localparam int unsigned WIDTH_BITS = 7;

    // Reset value of the row width register.
    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 7'd64;

    // Result queue depth and its pointer and level widths.
    localparam int unsigned OUT_DEPTH = 4;
    localparam int unsigned OUT_PTR_W = 2;
    localparam int unsigned OUT_CNT_W = 3;

    // Largest level at which a row may still be taken (room for two items).
    localparam logic [OUT_CNT_W-1:0] OUT_TAKE_MAX = 3'(OUT_DEPTH - 2);

    // Life rule counts.
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // Bits that one column shows to its neighbours.
    typedef struct packed {
        logic up;
        logic mid;
        logic row;
    } col_bits_t;

    // Row handling commands sent to every column.
    typedef struct packed {
        logic load;
        logic clear;
    } cell_ctrl_t;

    // One result item.
    typedef struct packed {
        logic [ROW_BITS-1:0] cells;
        logic                done;
    } result_t;

endpackage

### rtl/lgr_if.sv
// Handshake channels for board rows in and next-generation rows out.
interface lgr_row_if;
    logic                              valid;
    logic                              ready;
    logic [lgr_pkg::ROW_BITS-1:0]      row_cells;
    logic                              last_row;

    modport source (output valid, output row_cells, output last_row, input ready);
    modport sink (input valid, input row_cells, input last_row, output ready);
endinterface

interface lgr_gen_if;
    logic                              valid;
    logic                              ready;
    logic [lgr_pkg::ROW_BITS-1:0]      next_cells;
    logic                              frame_done;

    modport source (output valid, output next_cells, output frame_done, input ready);
    modport sink (input valid, input next_cells, input frame_done, output ready);
endinterface

### rtl/lgr_cell.sv
// One board column: holds the two previous rows' bits and applies the Life rule.
module lgr_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  lgr_pkg::cell_ctrl_t ctrl,
    input  logic               row_bit,
    input  logic               active,
    input  lgr_pkg::col_bits_t left,
    input  lgr_pkg::col_bits_t right,
    output lgr_pkg::col_bits_t here,
    output logic               gen_mid,
    output logic               gen_last
);

    logic       up_reg;
    logic       up_next;
    logic       mid_reg;
    logic       mid_next;
    logic [3:0] count_mid;
    logic [3:0] count_last;

    // Show held bits and the arriving bit to the neighbours
    assign here = '{up: up_reg, mid: mid_reg, row: row_bit};

    // Count neighbours around the held middle row
    assign count_mid = 4'(left.up) + 4'(up_reg) + 4'(right.up)
                     + 4'(left.mid) + 4'(right.mid)
                     + 4'(left.row) + 4'(row_bit) + 4'(right.row);

    // Count neighbours around the arriving row, dead row below
    assign count_last = 4'(left.mid) + 4'(mid_reg) + 4'(right.mid)
                      + 4'(left.row) + 4'(right.row);

    // Apply birth on three, survival on two or three
    assign gen_mid = active && ((count_mid == lgr_pkg::BIRTH_COUNT)
                     || (mid_reg && (count_mid == lgr_pkg::SURVIVE_COUNT)));
    assign gen_last = active && ((count_last == lgr_pkg::BIRTH_COUNT)
                      || (row_bit && (count_last == lgr_pkg::SURVIVE_COUNT)));

    // Shift rows down on a load, drop them at the frame end
    always_comb
    begin
        up_next  = up_reg;
        mid_next = mid_reg;
        if (ctrl.clear)
        begin
            up_next  = 1'b0;
            mid_next = 1'b0;
        end
        else if (ctrl.load)
        begin
            up_next  = mid_reg;
            mid_next = row_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg  <= 1'b0;
            mid_reg <= 1'b0;
        end
        else
        begin
            up_reg  <= up_next;
            mid_reg <= mid_next;
        end
    end

endmodule

### rtl/lgr_out_queue.sv
// Result queue that takes up to two items a cycle and gives one while out_ready is high.
module lgr_out_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_a,
    input  logic             push_b,
    input  lgr_pkg::result_t item_a,
    input  lgr_pkg::result_t item_b,
    output logic             has_room,
    output logic             out_valid,
    input  logic             out_ready,
    output lgr_pkg::result_t out_item
);

    lgr_pkg::result_t                 entry_reg [lgr_pkg::OUT_DEPTH];
    logic [lgr_pkg::OUT_PTR_W-1:0]    wr_ptr_reg;
    logic [lgr_pkg::OUT_PTR_W-1:0]    wr_ptr_next;
    logic [lgr_pkg::OUT_PTR_W-1:0]    rd_ptr_reg;
    logic [lgr_pkg::OUT_PTR_W-1:0]    rd_ptr_next;
    logic [lgr_pkg::OUT_CNT_W-1:0]    level_reg;
    logic [lgr_pkg::OUT_CNT_W-1:0]    level_next;
    logic [lgr_pkg::OUT_CNT_W-1:0]    push_n;
    logic                             pop;
    lgr_pkg::result_t                 first_item;

    assign push_n     = lgr_pkg::OUT_CNT_W'(push_a) + lgr_pkg::OUT_CNT_W'(push_b);
    assign first_item = push_a ? item_a : item_b;
    assign out_valid  = (level_reg != '0);
    assign out_item   = entry_reg[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    assign has_room   = (level_reg <= lgr_pkg::OUT_TAKE_MAX);

    // Advance pointers and level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + lgr_pkg::OUT_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + lgr_pkg::OUT_PTR_W'(pop);
        level_next  = level_reg + push_n - lgr_pkg::OUT_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Store one or two items at the write pointer
    always_ff @(posedge clk)
    begin
        if (push_n != '0)
        begin
            entry_reg[wr_ptr_reg] <= first_item;
        end
        if (push_a && push_b)
        begin
            entry_reg[wr_ptr_reg + lgr_pkg::OUT_PTR_W'(1)] <= item_b;
        end
    end

    // No push beyond the free space
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != '0) |-> (level_reg <= lgr_pkg::OUT_CNT_W'(lgr_pkg::OUT_DEPTH) - push_n))
        else $error("result queue overflow");

    // Level tracks pushes and pops
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (level_reg == $past(level_reg) + $past(push_n) - lgr_pkg::OUT_CNT_W'($past(pop))))
        else $error("result queue level out of step");

endmodule

### rtl/life_generation_row_stream_unit.sv
// Top level: one Life generation over a board streamed in row by row.
//
// Rows enter on row_in, top row first, with last_row set on the bottom row.
// Next-generation rows leave on gen_out; frame_done marks the bottom one.
// The first row of a frame gives no item; each later row gives the next
// state of the row above it, and the bottom row gives a second item, its
// own next state, with frame_done set. A one-row board gives one item.
// cfg_we / cfg_wdata write the active width; columns at or above it are
// dead, with zero taken as one and larger values as MAX_COLUMNS. Write it only while the block is idle.
// Throughput: one row per cycle while the result queue has room, set by the
// column cells, which hold the two previous rows and evaluate both possible
// results in the accepting cycle. The bottom row adds a second item, which
// gen_out sends after the first. An item is visible on gen_out the cycle
// after its row is accepted if the four-item result queue was empty.
// row_in.ready is high while the queue holds at most two items, so a
// stalled receiver stops row intake once the queue holds three or more items, with no loss.
// Reset clears the held rows, empties the queue and sets the width to 64.
module life_generation_row_stream_unit
#(
    parameter int unsigned MAX_COLUMNS = 64
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    lgr_row_if.sink                           row_in,
    lgr_gen_if.source                         gen_out,
    input  logic                              cfg_we,
    input  logic [lgr_pkg::WIDTH_BITS-1:0]    cfg_wdata
);

    localparam logic [lgr_pkg::WIDTH_BITS-1:0] MaxWidth = lgr_pkg::WIDTH_BITS'(MAX_COLUMNS);

    logic [lgr_pkg::WIDTH_BITS-1:0] row_width_reg;
    logic [lgr_pkg::WIDTH_BITS-1:0] eff_width;
    logic                           frame_open_reg;
    logic                           frame_open_next;
    logic                           take;
    logic                           has_room;
    lgr_pkg::cell_ctrl_t            ctrl;
    lgr_pkg::col_bits_t             col_bits [MAX_COLUMNS];
    logic [lgr_pkg::ROW_BITS-1:0]   gen_mid;
    logic [lgr_pkg::ROW_BITS-1:0]   gen_last;
    lgr_pkg::result_t               item_a;
    lgr_pkg::result_t               item_b;
    lgr_pkg::result_t               out_item;

    // Hold the width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= lgr_pkg::WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            row_width_reg <= cfg_wdata;
        end
    end

    // Clamp the width to the column range
    always_comb
    begin
        eff_width = row_width_reg;
        if (row_width_reg == '0)
        begin
            eff_width = lgr_pkg::WIDTH_BITS'(1);
        end
        else if (row_width_reg > MaxWidth)
        begin
            eff_width = MaxWidth;
        end
    end

    assign take          = row_in.valid && row_in.ready;
    assign row_in.ready  = has_room;
    assign ctrl.load     = take;
    assign ctrl.clear    = take && row_in.last_row;

    // Track whether the frame has a row held
    always_comb
    begin
        frame_open_next = frame_open_reg;
        if (take)
        begin
            frame_open_next = !row_in.last_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
        end
    end

    // Build the chain of column cells
    for (genvar c = 0; c < lgr_pkg::ROW_BITS; c++)
    begin : g_col
        if (c < MAX_COLUMNS)
        begin : g_cell
            logic               active;
            lgr_pkg::col_bits_t left;
            lgr_pkg::col_bits_t right;

            assign active = (lgr_pkg::WIDTH_BITS'(c) < eff_width);
            assign left   = (c == 0) ? '0 : col_bits[(c == 0) ? 0 : c - 1];
            assign right  = (c == MAX_COLUMNS - 1) ? '0
                          : col_bits[(c == MAX_COLUMNS - 1) ? c : c + 1];

            lgr_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .row_bit  (row_in.row_cells[c] && active),
                .active   (active),
                .left     (left),
                .right    (right),
                .here     (col_bits[c]),
                .gen_mid  (gen_mid[c]),
                .gen_last (gen_last[c])
            );
        end
        else
        begin : g_dead
            assign gen_mid[c]  = 1'b0;
            assign gen_last[c] = 1'b0;
        end
    end

    assign item_a = '{cells: gen_mid, done: 1'b0};
    assign item_b = '{cells: gen_last, done: 1'b1};

    // Queue results toward the receiver
    lgr_out_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_a    (take && frame_open_reg),
        .push_b    (take && row_in.last_row),
        .item_a    (item_a),
        .item_b    (item_b),
        .has_room  (has_room),
        .out_valid (gen_out.valid),
        .out_ready (gen_out.ready),
        .out_item  (out_item)
    );

    assign gen_out.next_cells = out_item.cells;
    assign gen_out.frame_done = out_item.done;

    // The bottom row closes the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && row_in.last_row) |=> !frame_open_reg)
        else $error("frame still open after bottom row");

    // Any row that yields an item leaves something to send
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && (frame_open_reg || row_in.last_row)) |=> gen_out.valid)
        else $error("result item missing after row");

    // A first row that is not the bottom opens the frame and sends nothing new
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && !frame_open_reg && !row_in.last_row) |=> frame_open_reg)
        else $error("frame did not open on first row");

endmodule

### dv/lgr_next_gen_checker.sv
// Checker for the Life row stream: predicts next-generation rows and compares them.
module lgr_next_gen_checker
#(
    parameter int unsigned MAX_COLUMNS = 64
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           row_valid,
    input  logic                           row_ready,
    input  logic [lgr_pkg::ROW_BITS-1:0]   row_cells,
    input  logic                           row_last,
    input  logic                           gen_valid,
    input  logic                           gen_ready,
    input  logic [lgr_pkg::ROW_BITS-1:0]   gen_cells,
    input  logic                           gen_done,
    input  logic                           cfg_we,
    input  logic [lgr_pkg::WIDTH_BITS-1:0] cfg_wdata,
    output int                             fail_count,
    output int                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Predicted board state: width in force, the two held rows and the row count.
    logic [lgr_pkg::WIDTH_BITS-1:0] width_q;
    logic [lgr_pkg::ROW_BITS-1:0]   above_row;
    logic [lgr_pkg::ROW_BITS-1:0]   held_row;
    logic [1:0]                     frame_rows;

    // Next-generation rows still awaited on the output channel, oldest first.
    lgr_pkg::result_t               pending_gens[$];

    // Live columns for the width in force; zero counts as one, oversize as the maximum.
    function automatic logic [lgr_pkg::ROW_BITS-1:0] live_columns(
        logic [lgr_pkg::WIDTH_BITS-1:0] w);
        int unsigned cols;
        cols = w;
        if (cols < 1)
            cols = 1;
        if (cols > MAX_COLUMNS)
            cols = MAX_COLUMNS;
        if (cols >= lgr_pkg::ROW_BITS)
            return '1;
        return (64'd1 << cols) - 64'd1;
    endfunction

    // Apply the birth-on-three, survive-on-two-or-three rule to the middle row.
    function automatic logic [lgr_pkg::ROW_BITS-1:0] evolve_row(
        logic [lgr_pkg::ROW_BITS-1:0] above,
        logic [lgr_pkg::ROW_BITS-1:0] here,
        logic [lgr_pkg::ROW_BITS-1:0] below,
        logic [lgr_pkg::ROW_BITS-1:0] mask);
        logic [lgr_pkg::ROW_BITS-1:0] nxt;
        int                           c;
        int                           d;
        int                           n;
        nxt = '0;
        for (c = 0; c < lgr_pkg::ROW_BITS; c++)
        begin
            n = 0;
            for (d = -1; d <= 1; d++)
            begin
                if (c + d >= 0 && c + d < lgr_pkg::ROW_BITS)
                begin
                    n = n + above[c+d] + below[c+d];
                    if (d != 0)
                        n = n + here[c+d];
                end
            end
            if (here[c])
                nxt[c] = (n == lgr_pkg::SURVIVE_COUNT) || (n == lgr_pkg::BIRTH_COUNT);
            else
                nxt[c] = (n == lgr_pkg::BIRTH_COUNT);
        end
        return nxt & mask;
    endfunction

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic [lgr_pkg::ROW_BITS-1:0] mask;
        logic [lgr_pkg::ROW_BITS-1:0] row;
        lgr_pkg::result_t             got;
        lgr_pkg::result_t             want;
        if (!rst_n)
        begin
            width_q    = lgr_pkg::WIDTH_RESET;
            above_row  = '0;
            held_row   = '0;
            frame_rows = '0;
            pending_gens.delete();
        end
        else
        begin
            // Compare an accepted output item with the oldest prediction.
            if (gen_valid && gen_ready)
            begin
                got.cells = gen_cells;
                got.done  = gen_done;
                if (pending_gens.size() == 0)
                begin
                    $error("unexpected item: next_cells %h frame_done %b", got.cells, got.done);
                    fail_count++;
                end
                else
                begin
                    want = pending_gens.pop_front();
                    if (got.cells !== want.cells)
                    begin
                        $error("next_cells mismatch: expected %h, actual %h",
                               want.cells, got.cells);
                        fail_count++;
                    end
                    if (got.done !== want.done)
                    begin
                        $error("frame_done mismatch: expected %b, actual %b",
                               want.done, got.done);
                        fail_count++;
                    end
                end
            end

            // Advance the predicted board on an accepted input row.
            if (row_valid && row_ready)
            begin
                mask = live_columns(width_q);
                row  = row_cells & mask;
                if (frame_rows == 2'd0)
                begin
                    above_row  = '0;
                    held_row   = row;
                    frame_rows = 2'd1;
                    if (row_last)
                    begin
                        pending_gens.push_back('{cells: evolve_row('0, row, '0, mask),
                                                 done: 1'b1});
                        held_row   = '0;
                        frame_rows = 2'd0;
                    end
                end
                else
                begin
                    pending_gens.push_back('{cells: evolve_row(above_row, held_row, row, mask),
                                             done: 1'b0});
                    above_row = held_row;
                    held_row  = row;
                    if (frame_rows < 2'd2)
                        frame_rows++;
                    if (row_last)
                    begin
                        pending_gens.push_back('{cells: evolve_row(above_row, held_row, '0, mask),
                                                 done: 1'b1});
                        above_row  = '0;
                        held_row   = '0;
                        frame_rows = 2'd0;
                    end
                end
            end

            // Take a width write; it applies from the next edge on.
            if (cfg_we)
                width_q = cfg_wdata;
        end
        outstanding = pending_gens.size();
    end

endmodule

### dv/tb_life_generation_row_stream_unit.sv
// Testbench top for the Life row stream: clock, reset, row stimulus and the verdict.
module tb_life_generation_row_stream_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COLS = 64;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [lgr_pkg::WIDTH_BITS-1:0] cfg_wdata;
    int                             fail_count;
    int                             outstanding;
    int                             send_idle_pct;
    int                             recv_stall_pct;
    int                             rows_in_phase;

    lgr_row_if row_if ();
    lgr_gen_if gen_if ();

    life_generation_row_stream_unit #(.MAX_COLUMNS(COLS)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_in    (row_if),
        .gen_out   (gen_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    lgr_next_gen_checker #(.MAX_COLUMNS(COLS)) checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .row_valid   (row_if.valid),
        .row_ready   (row_if.ready),
        .row_cells   (row_if.row_cells),
        .row_last    (row_if.last_row),
        .gen_valid   (gen_if.valid),
        .gen_ready   (gen_if.ready),
        .gen_cells   (gen_if.next_cells),
        .gen_done    (gen_if.frame_done),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // 12 ns clock.
    initial
        clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Stall the output channel at random.
    always @(negedge clk)
        gen_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Hard stop for a hung run.
    initial
    begin
        #5_000_000;
        $display("** life_generation_row_stream_unit: FAILED **");
        $finish;
    end

    // Offer one row, idling first at random, and hold it until it is taken.
    task automatic send_row(input logic [lgr_pkg::ROW_BITS-1:0] cells, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            row_if.valid <= 1'b0;
            @(negedge clk);
        end
        row_if.valid     <= 1'b1;
        row_if.row_cells <= cells;
        row_if.last_row  <= last;
        do
            @(posedge clk);
        while (!row_if.ready);
        @(negedge clk);
        rows_in_phase++;
    endtask

    // Pick row content: dense, sparse, single cell, blank, full, sparse with a three-cell run or plain random.
    function automatic logic [lgr_pkg::ROW_BITS-1:0] pick_row();
        logic [lgr_pkg::ROW_BITS-1:0] a;
        logic [lgr_pkg::ROW_BITS-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       return a & b;
            1:       return a | b;
            2:       return 64'd1 << $urandom_range(0, 63);
            3:       return '0;
            4:       return '1;
            5:       return (a & b) | (64'd7 << $urandom_range(0, 61));
            default: return a;
        endcase
    endfunction

    // Stream one board of random rows, flagging the bottom one.
    task automatic send_board(input int n_rows);
        int i;
        for (i = 0; i < n_rows; i++)
            send_row(pick_row(), i == n_rows - 1);
    endtask

    // Drop valid and wait until every predicted row has come out.
    task automatic drain();
        row_if.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write the width register while the block is idle.
    task automatic set_width(input logic [lgr_pkg::WIDTH_BITS-1:0] w);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        logic [lgr_pkg::WIDTH_BITS-1:0] width_plan [8];
        int                             p;
        int                             guard;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        row_if.valid     = 1'b0;
        row_if.row_cells = '0;
        row_if.last_row  = 1'b0;
        gen_if.ready     = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        rows_in_phase    = 0;

        // Hold reset, then release it on a falling edge.
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed boards at the reset width, no idling.
        // Single-row boards: full and blank.
        send_row('1, 1'b1);
        send_row('0, 1'b1);
        // Full board of three rows.
        send_row('1, 1'b0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        // Two-row checkerboard.
        send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_row(64'h5555_5555_5555_5555, 1'b1);
        // Vertical blinker, which turns horizontal.
        send_row(64'h0, 1'b0);
        send_row(64'h2, 1'b0);
        send_row(64'h2, 1'b0);
        send_row(64'h2, 1'b0);
        send_row(64'h0, 1'b1);
        // Cells on both edge columns.
        send_row(64'h8000_0000_0000_0001, 1'b0);
        send_row(64'h8000_0000_0000_0001, 1'b0);
        send_row(64'h8000_0000_0000_0001, 1'b1);
        // Glider against the top edge.
        send_row(64'h2, 1'b0);
        send_row(64'h4, 1'b0);
        send_row(64'h7, 1'b0);
        send_row(64'h0, 1'b1);
        drain();

        // Random phases: zero, one and oversize widths among them, each idling mode twice.
        width_plan = '{7'd0, 7'd1, 7'd127, 7'd2, 7'd63, 7'd65,
                       7'($urandom_range(3, 62)), 7'd64};
        for (p = 0; p < 8; p++)
        begin
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 65;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 65;
                end
                default:
                begin
                    send_idle_pct  = 37;
                    recv_stall_pct = 37;
                end
            endcase
            set_width(width_plan[p]);
            rows_in_phase = 0;
            while (rows_in_phase < 80)
            begin
                // Mostly short boards, some single rows, now and then a tall one.
                case ($urandom_range(0, 9))
                    0, 1:    send_board(1);
                    2:       send_board($urandom_range(12, 24));
                    default: send_board($urandom_range(2, 8));
                endcase
            end
            drain();
        end

        // Let any stray item surface, within a bound.
        guard = 0;
        while (outstanding != 0 && guard < 1000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (10) @(negedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("** life_generation_row_stream_unit: PASSED **");
        else
            $display("** life_generation_row_stream_unit: FAILED **");
        $finish;
    end

endmodule
